// ===== design/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the disciplined clock slew unit.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int TIME_W          = 64;
  localparam int SLOPE_W         = 32;
  localparam int TOL_W           = 63;
  localparam int FRAC_W          = 17;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 64;
  localparam int PROD_W          = TIME_W + SLOPE_W;
  localparam int SLOPE_FRAC_BITS = 30;  // Q2.30 rate
  localparam int LIMIT_FRAC_BITS = 16;  // Q1.16 fraction

  localparam logic [TOL_W-1:0]  TOL_RESET  = 63'd1000000;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd6554;

  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRACTION  = 8'd1;

  localparam logic [TIME_W-1:0] TIME_MIN = 64'h8000_0000_0000_0000;
  localparam logic [TIME_W-1:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic {
    OP_REF  = 1'b0,
    OP_TICK = 1'b1
  } tss_op_t;

  // word handed from the front to the back: reference time or elapsed local time
  typedef struct packed {
    tss_op_t             op;
    logic [TIME_W-1:0]   value;
    logic [SLOPE_W-1:0]  slope;
  } tss_entry_t;

  typedef struct packed {
    logic [TOL_W-1:0]  tolerance;
    logic [FRAC_W-1:0] fraction;
  } tss_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REF_OFS,
    S_REF_CMP,
    S_MAG,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_RES,
    S_CLAMP,
    S_UPDATE,
    S_EMIT
  } tss_state_t;

endpackage

// ===== design/tss_if.sv =====
// ----------------------------------------------------------------------------
// tss channel interfaces
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tss_item_if;
  logic                              valid;
  logic                              ready;
  tss_pkg::tss_op_t                  op;
  logic signed [tss_pkg::TIME_W-1:0] time_value;
  logic [tss_pkg::SLOPE_W-1:0]       slope;

  modport source (output valid, output op, output time_value, output slope, input ready);
  modport sink   (input valid, input op, input time_value, input slope, output ready);
endinterface

interface tss_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [tss_pkg::TIME_W-1:0] clock_time;
  logic signed [tss_pkg::TIME_W-1:0] bias_left;

  modport source (output valid, output clock_time, output bias_left, input ready);
  modport sink   (input valid, input clock_time, input bias_left, output ready);
endinterface

interface tss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tss_pkg::CFG_INDEX_W-1:0] index;
  logic [tss_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/time_sync_slew_unit.sv =====
// A reference word runs the back through REF_OFS, REF_CMP and EMIT; a tick word runs
// MAG, MUL_LO, MUL_HI, MUL_RES twice (advance, then limit), then CLAMP, UPDATE, EMIT.
// The back takes a new word only in IDLE; each product joins two 32x32 partial products.
// Front and queue take words while the back works or a result waits, till queue full.
// Reset (rst, synchronous): clock, bias, last local time and sync flag clear, queue
// empties, configuration returns to tolerance 1000000 and fraction 6554.
// ----------------------------------------------------------------------------
// time_sync_slew_unit
// Disciplined clock with stepping on large offsets and bounded bias slewing.
// ----------------------------------------------------------------------------
module time_sync_slew_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  tss_item_if.sink      item,
  tss_result_if.source  result,
  tss_cfg_if.sink       cfg
);

  tss_pkg::tss_cfg_t   cfg_regs;
  logic                q_in_valid;
  logic                q_in_ready;
  tss_pkg::tss_entry_t q_in_entry;
  logic                q_out_valid;
  logic                q_out_ready;
  tss_pkg::tss_entry_t q_out_entry;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.tolerance <= tss_pkg::TOL_RESET;
      cfg_regs.fraction  <= tss_pkg::FRAC_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tss_pkg::CFG_TOLERANCE: cfg_regs.tolerance <= cfg.data[tss_pkg::TOL_W-1:0];
        tss_pkg::CFG_FRACTION:  cfg_regs.fraction  <= cfg.data[tss_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  tss_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_in_valid),
    .q_entry (q_in_entry),
    .q_ready (q_in_ready)
  );

  tss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_entry (q_in_entry),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_entry  (q_out_entry)
  );

  tss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_valid  (q_out_valid),
    .q_entry  (q_out_entry),
    .q_ready  (q_out_ready),
    .result   (result)
  );

`ifndef NO_ASSERTIONS
  a_cfg_reset: assert property (@(posedge clk)
    rst |=> (cfg_regs.tolerance == tss_pkg::TOL_RESET &&
             cfg_regs.fraction == tss_pkg::FRAC_RESET))
    else $error("config not at reset values after reset");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (q_out_valid && q_out_ready) |=> !q_out_ready)
    else $error("back took a second word while busy");

  a_stage_push: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> q_in_valid)
    else $error("accepted word not offered to queue");
`endif

endmodule

// ===== design/tss_front.sv =====
// ----------------------------------------------------------------------------
// tss_front
// Accepts input words, classifies them and turns tick times into elapsed time.
// ----------------------------------------------------------------------------
module tss_front (
  input  logic                clk,
  input  logic                rst,
  tss_item_if.sink            item,
  output logic                q_valid,
  output tss_pkg::tss_entry_t q_entry,
  input  logic                q_ready
);

  logic                        stage_valid;
  logic [tss_pkg::TIME_W-1:0]  last_local;
  logic [tss_pkg::TIME_W-1:0]  base;
  tss_pkg::tss_entry_t         entry_next;
  logic                        accept;

  assign item.ready = !stage_valid || q_ready;
  assign accept     = item.valid && item.ready;
  assign q_valid    = stage_valid;

  always_comb begin
    // a zero last local time means no tick yet: elapsed is zero
    base             = (last_local == '0) ? item.time_value : last_local;
    entry_next.op    = item.op;
    entry_next.slope = item.slope;
    unique case (item.op)
      tss_pkg::OP_REF:  entry_next.value = item.time_value;
      tss_pkg::OP_TICK: entry_next.value = item.time_value - base;
      default:          entry_next.value = item.time_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      last_local  <= '0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
        if (item.op == tss_pkg::OP_TICK) begin
          last_local <= item.time_value;
        end
      end else if (q_ready) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_entry <= entry_next;
    end
  end

endmodule

// ===== design/tss_queue.sv =====
// ----------------------------------------------------------------------------
// tss_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module tss_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  tss_pkg::tss_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tss_pkg::tss_entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tss_pkg::tss_entry_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push;
  logic                pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== design/tss_back.sv =====
// ----------------------------------------------------------------------------
// tss_back
// Sequencer that applies reference and tick words to the disciplined clock.
// ----------------------------------------------------------------------------
module tss_back (
  input  logic                clk,
  input  logic                rst,
  input  tss_pkg::tss_cfg_t   cfg_regs,
  input  logic                q_valid,
  input  tss_pkg::tss_entry_t q_entry,
  output logic                q_ready,
  tss_result_if.source        result
);

  localparam int TW = tss_pkg::TIME_W;
  localparam int SW = tss_pkg::SLOPE_W;
  localparam int PW = tss_pkg::PROD_W;

  tss_pkg::tss_state_t state, state_next;

  logic [TW-1:0] clk_time;
  logic [TW-1:0] bias;
  logic          synced;
  logic [TW-1:0] opnd;
  logic [TW-1:0] offset;
  logic [SW-1:0] slope_r;
  logic [TW-1:0] mag;
  logic          mag_neg;
  logic [SW-1:0] mul_b;
  logic          phase_lim;
  logic [TW-1:0] lo;
  logic [TW-1:0] hi;
  logic [TW-1:0] advance;
  logic [TW-1:0] limit;
  logic          bias_pos;
  logic          out_valid;
  logic [TW-1:0] out_time;
  logic [TW-1:0] out_bias;

  logic [PW-1:0] prod;
  logic [PW-1:0] shifted;
  logic [TW-1:0] r;
  logic          upper_nz;
  logic [TW-1:0] mul_sat;
  logic          bias_is_pos;
  logic [TW-1:0] bias_mag;
  logic [TW-1:0] clamped;
  logic [TW-1:0] tol64;
  logic [TW-1:0] neg_tol;
  logic          step;
  logic          out_load;

  // product assembly, truncating shift and saturation
  always_comb begin
    prod     = {{(PW-TW){1'b0}}, lo} + {hi[PW-SW-1:0], {SW{1'b0}}};
    shifted  = phase_lim ? (prod >> tss_pkg::LIMIT_FRAC_BITS)
                         : (prod >> tss_pkg::SLOPE_FRAC_BITS);
    r        = shifted[TW-1:0];
    upper_nz = |shifted[PW-1:TW];
    if (mag_neg) begin
      mul_sat = (upper_nz || (r > tss_pkg::TIME_MIN)) ? tss_pkg::TIME_MIN : -r;
    end else begin
      mul_sat = (upper_nz || r[TW-1]) ? tss_pkg::TIME_MAX : r;
    end
  end

  // per-tick correction limit against the pending bias
  always_comb begin
    bias_is_pos = !bias[TW-1] && (bias != '0);
    bias_mag    = -bias;
    if (bias_is_pos) begin
      clamped = ($signed(bias) < $signed(limit)) ? bias : limit;
    end else begin
      clamped = (!limit[TW-1] && (limit != '0) && (bias_mag < limit)) ? bias_mag : limit;
    end
  end

  always_comb begin
    tol64   = {1'b0, cfg_regs.tolerance};
    neg_tol = -tol64;
    step    = !synced || ($signed(offset) > $signed(tol64))
                      || ($signed(offset) < $signed(neg_tol));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      tss_pkg::S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_next = (q_entry.op == tss_pkg::OP_REF) ? tss_pkg::S_REF_OFS
                                                       : tss_pkg::S_MAG;
        end
      end
      tss_pkg::S_REF_OFS: state_next = tss_pkg::S_REF_CMP;
      tss_pkg::S_REF_CMP: state_next = tss_pkg::S_EMIT;
      tss_pkg::S_MAG:     state_next = tss_pkg::S_MUL_LO;
      tss_pkg::S_MUL_LO:  state_next = tss_pkg::S_MUL_HI;
      tss_pkg::S_MUL_HI:  state_next = tss_pkg::S_MUL_RES;
      tss_pkg::S_MUL_RES: state_next = phase_lim ? tss_pkg::S_CLAMP : tss_pkg::S_MAG;
      tss_pkg::S_CLAMP:   state_next = tss_pkg::S_UPDATE;
      tss_pkg::S_UPDATE:  state_next = tss_pkg::S_EMIT;
      tss_pkg::S_EMIT: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = tss_pkg::S_IDLE;
        end
      end
      default: state_next = tss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_time <= '0;
      bias     <= '0;
      synced   <= 1'b0;
    end else begin
      case (state)
        tss_pkg::S_IDLE: begin
          if (q_valid) begin
            opnd      <= q_entry.value;
            slope_r   <= q_entry.slope;
            phase_lim <= 1'b0;
          end
        end
        tss_pkg::S_REF_OFS: offset <= opnd - clk_time;
        tss_pkg::S_REF_CMP: begin
          if (step) begin
            clk_time <= opnd;
            bias     <= '0;
          end else begin
            bias <= offset;
          end
          synced <= 1'b1;
        end
        tss_pkg::S_MAG: begin
          mag     <= opnd[TW-1] ? -opnd : opnd;
          mag_neg <= opnd[TW-1];
          mul_b   <= phase_lim ? SW'(cfg_regs.fraction) : slope_r;
        end
        tss_pkg::S_MUL_LO: lo <= TW'(mag[SW-1:0] * mul_b);
        tss_pkg::S_MUL_HI: hi <= TW'(mag[TW-1:SW] * mul_b);
        tss_pkg::S_MUL_RES: begin
          if (phase_lim) begin
            limit <= mul_sat;
          end else begin
            advance   <= mul_sat;
            opnd      <= mul_sat;
            phase_lim <= 1'b1;
          end
        end
        tss_pkg::S_CLAMP: begin
          bias_pos <= bias_is_pos;
          limit    <= clamped;
        end
        tss_pkg::S_UPDATE: begin
          if (bias_pos) begin
            bias     <= bias - limit;
            clk_time <= clk_time + advance + limit;
          end else begin
            bias     <= bias + limit;
            clk_time <= clk_time + advance - limit;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_time <= clk_time;
      out_bias <= bias;
    end
  end

  assign result.valid      = out_valid;
  assign result.clock_time = out_time;
  assign result.bias_left  = out_bias;

endmodule
